>>> design/tcwfs_pkg.sv
// shared constants, codes and types of the three-class weighted fifo scheduler
`timescale 1ns / 1ps

package tcwfs_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 3;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // field widths
    localparam int TICKET_W = 16;
    localparam int AGE_W    = 7;
    localparam int GROUP_W  = 2;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;
    localparam int TURNS_W  = 4;
    localparam int ENTRY_W  = TICKET_W + AGE_W;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [AGE_W-1:0]   AGE_THR_RST      = 7'd60;
    localparam logic [TURNS_W-1:0] SENIOR_TURNS_RST = 4'd4;
    localparam logic [TURNS_W-1:0] ADULT_TURNS_RST  = 4'd4;
    localparam logic [TURNS_W-1:0] B_TURNS_RST      = 4'd2;

    // group codes of an insert
    localparam logic [GROUP_W-1:0] GRP_A = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_B = 2'd1;

    // request function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SERVE  = 1'b1;

    typedef enum logic [1:0] {
        REG_AGE_THR      = 2'd0,
        REG_SENIOR_TURNS = 2'd1,
        REG_ADULT_TURNS  = 2'd2,
        REG_B_TURNS      = 2'd3
    } reg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_BAD_GROUP = 3'd1,
        ST_FULL      = 3'd2,
        ST_SERVED    = 3'd3,
        ST_ALL_EMPTY = 3'd4,
        ST_SKIPPED   = 3'd5
    } status_t;

    typedef enum logic [CLASS_W-1:0] {
        CL_SENIOR = 2'd0,
        CL_ADULT  = 2'd1,
        CL_B      = 2'd2
    } class_t;

    typedef struct packed {
        logic [AGE_W-1:0]   age_threshold;
        logic [TURNS_W-1:0] senior_turns;
        logic [TURNS_W-1:0] adult_turns;
        logic [TURNS_W-1:0] group_b_turns;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic exec;      // transaction accepted this cycle
        logic load_mem;  // store read data lands in the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // result register empty or being taken
        logic serve_hit; // current request pops an entry
    } dp_stat_t;

endpackage

>>> design/tcwfs_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface tcwfs_req_if;
    import tcwfs_pkg::*;

    logic                valid;
    logic                ready;
    logic                func;
    logic [TICKET_W-1:0] ticket;
    logic [AGE_W-1:0]    age;
    logic [GROUP_W-1:0]  group;

    modport source (output valid, output func, output ticket, output age, output group,
                    input ready);
    modport sink   (input valid, input func, input ticket, input age, input group,
                    output ready);
endinterface

interface tcwfs_rsp_if;
    import tcwfs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  queue_class;
    logic [TICKET_W-1:0] served_ticket;
    logic [AGE_W-1:0]    served_age;

    modport source (output valid, output status, output queue_class,
                    output served_ticket, output served_age, input ready);
    modport sink   (input valid, input status, input queue_class,
                    input served_ticket, input served_age, output ready);
endinterface

>>> design/three_class_weighted_fifo_scheduler.sv
// top level of the three-class weighted fifo scheduler
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  func, ticket, age, group
//  rsp      out  rsp.valid/rsp.ready  status, queue_class, served_ticket, served_age
//  apb      in   psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  an insert, a rejected request, a skipped turn or an all-empty serve writes the
//  result register directly; a popping serve fills it from the registered read of
//  the entry store that holds all three ring buffers; with no such read in flight,
//  a new transaction is taken while the result register is empty or being taken
//  reset clears pointers, fill counts and the turn counter at once; the entry store
//  is not cleared and is read only where an entry is held
//  a stalled response holds the result register and, with it, the request side
`timescale 1ns / 1ps

module three_class_weighted_fifo_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    tcwfs_req_if.sink                     req,
    tcwfs_rsp_if.source                   rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcwfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tcwfs_pkg::PDATA_W-1:0] pwdata,
    output logic [tcwfs_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import tcwfs_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // register file: threshold and the three turn counts
    tcwfs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller: decides when a transaction is accepted and when read data lands
    tcwfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: queue selection, pointers, turn counter, store and result register
    tcwfs_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg               (cfg),
        .req_func          (req.func),
        .req_ticket        (req.ticket),
        .req_age           (req.age),
        .req_group         (req.group),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_queue_class   (rsp.queue_class),
        .rsp_served_ticket (rsp.served_ticket),
        .rsp_served_age    (rsp.served_age)
    );

    // no new transaction while a result is stuck in the output register
    a_no_accept_over_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        req.ready |-> (!rsp.valid || rsp.ready)
    ) else $error("request accepted while result register is stalled");

    // a popping serve is followed by the store read data landing
    a_hit_then_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.serve_hit) |=> cmd.load_mem
    ) else $error("serve hit not followed by store read");

    // the result register is empty when store read data lands
    a_load_into_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_mem |-> !rsp.valid
    ) else $error("store read data would overwrite a pending result");

    // no transaction is taken while the store read is in flight
    a_no_accept_during_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_mem |-> !req.ready
    ) else $error("request accepted during store read");

endmodule

>>> design/tcwfs_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module tcwfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/tcwfs_cfg.sv
// apb-style configuration register file
`timescale 1ns / 1ps

module tcwfs_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcwfs_pkg::PADDR_W-1:0] paddr,
    input  logic [tcwfs_pkg::PDATA_W-1:0] pwdata,
    output logic [tcwfs_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output tcwfs_pkg::cfg_t               cfg
);
    import tcwfs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_AGE_THR:      cfg_next.age_threshold = pwdata[AGE_W-1:0];
                REG_SENIOR_TURNS: cfg_next.senior_turns  = pwdata[TURNS_W-1:0];
                REG_ADULT_TURNS:  cfg_next.adult_turns   = pwdata[TURNS_W-1:0];
                REG_B_TURNS:      cfg_next.group_b_turns = pwdata[TURNS_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_AGE_THR:      prdata = PDATA_W'(cfg_reg.age_threshold);
            REG_SENIOR_TURNS: prdata = PDATA_W'(cfg_reg.senior_turns);
            REG_ADULT_TURNS:  prdata = PDATA_W'(cfg_reg.adult_turns);
            REG_B_TURNS:      prdata = PDATA_W'(cfg_reg.group_b_turns);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.age_threshold <= AGE_THR_RST;
            cfg_reg.senior_turns  <= SENIOR_TURNS_RST;
            cfg_reg.adult_turns   <= ADULT_TURNS_RST;
            cfg_reg.group_b_turns <= B_TURNS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/tcwfs_ctrl.sv
// controller state machine: accept, then wait for store read data on a popping serve
`timescale 1ns / 1ps

module tcwfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tcwfs_pkg::dp_stat_t   stat,
    output tcwfs_pkg::ctrl_cmd_t  cmd
);
    import tcwfs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready    = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.exec     = req_valid && req_ready;
    assign cmd.load_mem = (state_reg == S_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec && stat.serve_hit)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/tcwfs_dp.sv
// datapath: queue pointers, turn counter, entry store and result register
`timescale 1ns / 1ps

module tcwfs_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcwfs_pkg::ctrl_cmd_t           cmd,
    output tcwfs_pkg::dp_stat_t            stat,
    input  tcwfs_pkg::cfg_t                cfg,
    input  logic                           req_func,
    input  logic [tcwfs_pkg::TICKET_W-1:0] req_ticket,
    input  logic [tcwfs_pkg::AGE_W-1:0]    req_age,
    input  logic [tcwfs_pkg::GROUP_W-1:0]  req_group,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output logic [tcwfs_pkg::STATUS_W-1:0] rsp_status,
    output logic [tcwfs_pkg::CLASS_W-1:0]  rsp_queue_class,
    output logic [tcwfs_pkg::TICKET_W-1:0] rsp_served_ticket,
    output logic [tcwfs_pkg::AGE_W-1:0]    rsp_served_age
);
    import tcwfs_pkg::*;

    // queue bookkeeping
    logic [IDX_W-1:0]   head_reg [NUM_QUEUES];
    logic [IDX_W-1:0]   head_next [NUM_QUEUES];
    logic [IDX_W-1:0]   tail_reg [NUM_QUEUES];
    logic [IDX_W-1:0]   tail_next [NUM_QUEUES];
    logic [OCC_W-1:0]   occ_reg [NUM_QUEUES];
    logic [OCC_W-1:0]   occ_next [NUM_QUEUES];

    // turn counter
    class_t             phase_reg;
    class_t             phase_next;
    logic [TURNS_W-1:0] turns_reg;
    logic [TURNS_W-1:0] turns_next;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    class_t             out_class_reg;
    class_t             out_class_next;
    logic [TICKET_W-1:0] out_ticket_reg;
    logic [TICKET_W-1:0] out_ticket_next;
    logic [AGE_W-1:0]   out_age_reg;
    logic [AGE_W-1:0]   out_age_next;

    // decision
    class_t             serve_q;
    class_t             ins_q;
    class_t             q;
    logic [OCC_W-1:0]   occ_q;
    logic               bad_group;
    logic               full;
    logic               all_empty;
    logic               hit;
    logic               do_write;
    logic               do_read;
    status_t            res_status;
    class_t             res_class;

    // store port
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
        if (v == IDX_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return v + 1'b1;
    endfunction

    function automatic logic [TURNS_W-1:0] turns_of(input class_t ph, input cfg_t c);
        logic [TURNS_W-1:0] t;
        case (ph)
            CL_ADULT: t = c.adult_turns;
            CL_B:     t = c.group_b_turns;
            default:  t = c.senior_turns;
        endcase
        return t;
    endfunction

    always_comb
    begin
        case (phase_reg)
            CL_ADULT: serve_q = CL_ADULT;
            CL_B:     serve_q = CL_B;
            default:  serve_q = CL_SENIOR;
        endcase
    end

    assign ins_q     = (req_group == GRP_A) ?
                       ((req_age >= cfg.age_threshold) ? CL_SENIOR : CL_ADULT) : CL_B;
    assign bad_group = (req_group != GRP_A) && (req_group != GRP_B);
    assign q         = (req_func == FUNC_SERVE) ? serve_q : ins_q;
    assign occ_q     = occ_reg[q];
    assign full      = (occ_q == OCC_W'(QUEUE_DEPTH));
    assign all_empty = (occ_reg[CL_SENIOR] == '0) && (occ_reg[CL_ADULT] == '0) &&
                       (occ_reg[CL_B] == '0);
    assign hit       = (req_func == FUNC_SERVE) && !all_empty && (occ_q != '0);
    assign do_write  = cmd.exec && (req_func == FUNC_INSERT) && !bad_group && !full;
    assign do_read   = cmd.exec && hit;

    always_comb
    begin
        res_class = q;
        if (req_func == FUNC_INSERT)
        begin
            if (bad_group)
            begin
                res_status = ST_BAD_GROUP;
                res_class  = CL_SENIOR;
            end
            else if (full)
            begin
                res_status = ST_FULL;
            end
            else
            begin
                res_status = ST_INSERTED;
            end
        end
        else if (all_empty)
        begin
            res_status = ST_ALL_EMPTY;
            res_class  = CL_SENIOR;
        end
        else if (hit)
        begin
            res_status = ST_SERVED;
        end
        else
        begin
            res_status = ST_SKIPPED;
        end
    end

    // pointer and occupancy update
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            head_next[i] = head_reg[i];
            tail_next[i] = tail_reg[i];
            occ_next[i]  = occ_reg[i];
        end
        if (do_write)
        begin
            tail_next[q] = idx_inc(tail_reg[q]);
            occ_next[q]  = occ_reg[q] + 1'b1;
        end
        if (do_read)
        begin
            head_next[q] = idx_inc(head_reg[q]);
            occ_next[q]  = occ_reg[q] - 1'b1;
        end
    end

    // weighted turn counter
    always_comb
    begin
        phase_next = phase_reg;
        turns_next = turns_reg;
        if (cmd.exec && (req_func == FUNC_SERVE))
        begin
            if (all_empty)
            begin
                phase_next = CL_SENIOR;
            end
            else if (hit)
            begin
                if (turns_reg <= 4'd1)
                begin
                    case (q)
                        CL_SENIOR: phase_next = CL_ADULT;
                        CL_ADULT:  phase_next = CL_B;
                        default:   phase_next = CL_SENIOR;
                    endcase
                end
            end
            else
            begin
                case (q)
                    CL_SENIOR:
                    begin
                        if (occ_reg[CL_ADULT] == '0)
                        begin
                            phase_next = CL_B;
                        end
                        else if (occ_reg[CL_B] == '0)
                        begin
                            phase_next = CL_SENIOR;
                        end
                        else
                        begin
                            phase_next = CL_ADULT;
                        end
                    end
                    CL_ADULT:
                    begin
                        phase_next = (occ_reg[CL_B] == '0) ? CL_SENIOR : CL_B;
                    end
                    default:
                    begin
                        phase_next = CL_SENIOR;
                    end
                endcase
            end
            // a serve that pops with turns left counts down, any other serve reloads
            if (hit && (turns_reg > 4'd1))
            begin
                turns_next = turns_reg - 1'b1;
            end
            else
            begin
                turns_next = turns_of(phase_next, cfg);
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_class_next  = out_class_reg;
        out_ticket_next = out_ticket_reg;
        out_age_next    = out_age_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            out_status_next = res_status;
            out_class_next  = res_class;
            out_ticket_next = '0;
            out_age_next    = '0;
            out_valid_next  = !hit;
        end
        if (cmd.load_mem)
        begin
            out_ticket_next = rdata[ENTRY_W-1:AGE_W];
            out_age_next    = rdata[AGE_W-1:0];
            out_valid_next  = 1'b1;
        end
    end

    assign stat.out_free  = !out_valid_reg || rsp_ready;
    assign stat.serve_hit = hit;

    assign rsp_valid         = out_valid_reg;
    assign rsp_status        = out_status_reg;
    assign rsp_queue_class   = out_class_reg;
    assign rsp_served_ticket = out_ticket_reg;
    assign rsp_served_age    = out_age_reg;

    // store address: queue base plus ring index
    assign base_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH);
    assign waddr     = base_addr + ADDR_W'(tail_reg[q]);
    assign raddr     = base_addr + ADDR_W'(head_reg[q]);

    tcwfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (waddr),
        .wdata ({req_ticket, req_age}),
        .re    (do_read),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
            phase_reg     <= CL_SENIOR;
            turns_reg     <= SENIOR_TURNS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= head_next[i];
                tail_reg[i] <= tail_next[i];
                occ_reg[i]  <= occ_next[i];
            end
            phase_reg     <= phase_next;
            turns_reg     <= turns_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_class_reg  <= out_class_next;
        out_ticket_reg <= out_ticket_next;
        out_age_reg    <= out_age_next;
    end

endmodule

>>> test/tb.sv
// self-checking testbench of the three-class weighted fifo scheduler
`timescale 1ns / 1ps

module tb;
    import tcwfs_pkg::*;

    // the two group codes that the block rejects
    localparam logic [GROUP_W-1:0] GRP_BAD_LO = 2'd2;
    localparam logic [GROUP_W-1:0] GRP_BAD_HI = 2'd3;

    // cycles allowed after the last result, and the receiver hold-off length
    localparam int END_SETTLE   = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 140;
    localparam int NUM_SETTINGS = 5;

    // one request transaction and the result that it is expected to produce
    typedef struct packed {
        logic                func;
        logic [TICKET_W-1:0] ticket;
        logic [AGE_W-1:0]    age;
        logic [GROUP_W-1:0]  group;
    } sched_request_t;

    typedef struct packed {
        status_t             status;
        class_t              qclass;
        logic [TICKET_W-1:0] ticket;
        logic [AGE_W-1:0]    age;
    } sched_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tcwfs_req_if req_ch ();
    tcwfs_rsp_if rsp_ch ();

    three_class_weighted_fifo_scheduler uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scheduler predictor: its own copy of the three ring buffers,
    // the weighted turn counter and the configuration registers
    // ------------------------------------------------------------------
    logic [TICKET_W-1:0] held_ticket [NUM_QUEUES][QUEUE_DEPTH];
    logic [AGE_W-1:0]    held_age    [NUM_QUEUES][QUEUE_DEPTH];
    int                  head_pos    [NUM_QUEUES];
    int                  tail_pos    [NUM_QUEUES];
    int                  fill_count  [NUM_QUEUES];
    class_t              turn_phase;
    int                  turns_left;

    logic [AGE_W-1:0]    age_thr_cfg;
    logic [TURNS_W-1:0]  senior_turns_cfg;
    logic [TURNS_W-1:0]  adult_turns_cfg;
    logic [TURNS_W-1:0]  b_turns_cfg;

    // results still owed by the block, oldest first
    sched_result_t pending_results [$];

    // stimulus knobs and bookkeeping
    int   send_idle_pct  = 0;
    int   rsp_stall_pct  = 0;
    logic hold_rsp       = 1'b0;
    int   mismatch_count = 0;
    int   requests_sent  = 0;
    int   reg_writes     = 0;
    int   seen_stored    = 0;
    int   seen_served    = 0;
    int   seen_skipped   = 0;
    int   seen_full      = 0;
    int   seen_bad_group = 0;
    int   seen_all_empty = 0;

    // load the turn budget of a phase; a new count only takes effect here
    function automatic void start_phase(class_t ph);
        turn_phase = ph;
        case (ph)
            CL_SENIOR: turns_left = int'(senior_turns_cfg);
            CL_ADULT:  turns_left = int'(adult_turns_cfg);
            default:   turns_left = int'(b_turns_cfg);
        endcase
    endfunction

    // advance the predictor by one accepted request and return its result
    function automatic sched_result_t schedule_step(sched_request_t r);
        sched_result_t res;
        class_t        tgt;
        int            pos;

        res.status = ST_INSERTED;
        res.qclass = CL_SENIOR;
        res.ticket = '0;
        res.age    = '0;

        if (r.func == FUNC_INSERT)
        begin
            // group a splits on the age threshold, group b has its own queue
            if (r.group == GRP_A)
                tgt = (r.age >= age_thr_cfg) ? CL_SENIOR : CL_ADULT;
            else if (r.group == GRP_B)
                tgt = CL_B;
            else
            begin
                res.status = ST_BAD_GROUP;
                return res;
            end
            res.qclass = tgt;
            if (fill_count[tgt] >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
                return res;
            end
            pos = tail_pos[tgt];
            held_ticket[tgt][pos] = r.ticket;
            held_age[tgt][pos]    = r.age;
            tail_pos[tgt]   = (pos + 1) % QUEUE_DEPTH;
            fill_count[tgt] = fill_count[tgt] + 1;
            return res;
        end

        // serve with nothing held: counter goes back to the senior phase
        if (fill_count[CL_SENIOR] == 0 && fill_count[CL_ADULT] == 0 && fill_count[CL_B] == 0)
        begin
            res.status = ST_ALL_EMPTY;
            start_phase(CL_SENIOR);
            return res;
        end

        tgt        = turn_phase;
        res.qclass = tgt;
        if (fill_count[tgt] != 0)
        begin
            pos = head_pos[tgt];
            res.status = ST_SERVED;
            res.ticket = held_ticket[tgt][pos];
            res.age    = held_age[tgt][pos];
            head_pos[tgt]   = (pos + 1) % QUEUE_DEPTH;
            fill_count[tgt] = fill_count[tgt] - 1;
            // a zero turn count behaves as a single turn
            if (turns_left <= 1)
                start_phase(tgt == CL_B ? CL_SENIOR : class_t'(tgt + 1));
            else
                turns_left = turns_left - 1;
            return res;
        end

        // turn owner is empty: nothing served, counter jumps ahead or back to senior
        res.status = ST_SKIPPED;
        case (tgt)
            CL_SENIOR:
            begin
                if (fill_count[CL_ADULT] == 0)
                    start_phase(CL_B);
                else if (fill_count[CL_B] == 0)
                    start_phase(CL_SENIOR);
                else
                    start_phase(CL_ADULT);
            end
            CL_ADULT: start_phase(fill_count[CL_B] == 0 ? CL_SENIOR : CL_B);
            default:  start_phase(CL_SENIOR);
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    // every result transaction is matched against the oldest expectation
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, status", -1,
                                int'(rsp_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", int'(want.status), int'(rsp_ch.status));
                if (rsp_ch.queue_class !== want.qclass)
                    report_mismatch("queue_class", int'(want.qclass),
                                    int'(rsp_ch.queue_class));
                if (rsp_ch.served_ticket !== want.ticket)
                    report_mismatch("served_ticket", int'(want.ticket),
                                    int'(rsp_ch.served_ticket));
                if (rsp_ch.served_age !== want.age)
                    report_mismatch("served_age", int'(want.age), int'(rsp_ch.served_age));
                case (want.status)
                    ST_INSERTED:  seen_stored++;
                    ST_SERVED:    seen_served++;
                    ST_SKIPPED:   seen_skipped++;
                    ST_FULL:      seen_full++;
                    ST_BAD_GROUP: seen_bad_group++;
                    default:      seen_all_empty++;
                endcase
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when the pressure test asks
    always @(negedge clk)
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one request transaction and log its expected result on acceptance
    task automatic send_request(input logic fn, input logic [TICKET_W-1:0] tk,
                                input logic [AGE_W-1:0] ag, input logic [GROUP_W-1:0] gp);
        sched_request_t r;
        int             gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 2) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid  <= 1'b1;
        req_ch.func   <= fn;
        req_ch.ticket <= tk;
        req_ch.age    <= ag;
        req_ch.group  <= gp;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        r.func   = fn;
        r.ticket = tk;
        r.age    = ag;
        r.group  = gp;
        pending_results.push_back(schedule_step(r));
        requests_sent++;
    endtask

    // stop offering and wait until every owed result has come back
    task automatic wait_for_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup then access; register takes the value at the access edge
    task automatic write_register(input reg_idx_t ri, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ri, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (ri)
            REG_AGE_THR:      age_thr_cfg      = data[AGE_W-1:0];
            REG_SENIOR_TURNS: senior_turns_cfg = data[TURNS_W-1:0];
            REG_ADULT_TURNS:  adult_turns_cfg  = data[TURNS_W-1:0];
            default:          b_turns_cfg      = data[TURNS_W-1:0];
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked requests with reset configuration: field extremes, the
    // threshold boundary, bad groups and skips, resets and a rollover of the turn counter
    task automatic test_directed();
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);      // all queues empty
        send_request(FUNC_INSERT, 16'h1234, 7'd30,  GRP_BAD_LO); // bad group
        send_request(FUNC_INSERT, 16'hFFFF, 7'd127, GRP_BAD_HI); // bad group
        send_request(FUNC_INSERT, 16'hFFFF, 7'd60,  GRP_A);      // at threshold, senior
        send_request(FUNC_INSERT, 16'h0000, 7'd59,  GRP_A);      // just below, adult
        send_request(FUNC_INSERT, 16'h8001, 7'd127, GRP_A);
        send_request(FUNC_INSERT, 16'h7FFE, 7'd0,   GRP_A);
        send_request(FUNC_INSERT, 16'hAAAA, 7'h55,  GRP_B);
        send_request(FUNC_SERVE,  16'hFFFF, 7'd127, GRP_BAD_HI);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        // senior runs dry with adult and b waiting: jump to adult
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        // adult runs dry with b waiting: jump to b
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        // b entry takes the last b turn, then serves find every queue empty
        send_request(FUNC_INSERT, 16'h5555, 7'h2A,  GRP_B);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        // only adult held: senior turn skips and stays on senior
        send_request(FUNC_INSERT, 16'h0F0F, 7'd10,  GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        send_request(FUNC_SERVE,  16'h0000, 7'd0,   GRP_A);
        // two b entries back to back end the last b turn
        send_request(FUNC_INSERT, 16'hF0F0, 7'd1,   GRP_B);
        send_request(FUNC_INSERT, 16'h00FF, 7'd126, GRP_B);
        repeat (5) send_request(FUNC_SERVE, 16'h0000, 7'd0, GRP_A);
        wait_for_idle();
    endtask

    // receiver holds off while the sender keeps offering, then every queue is
    // overfilled and drained again
    task automatic test_backpressure_fill();
        fork
            begin
                hold_rsp = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        for (int i = 0; i < QUEUE_DEPTH + 4; i++)
        begin
            send_request(FUNC_INSERT, TICKET_W'($urandom_range(16'hFFFF)),
                         AGE_W'($urandom_range(127)), GRP_B);
            send_request(FUNC_INSERT, TICKET_W'($urandom_range(16'hFFFF)), 7'd127, GRP_A);
            send_request(FUNC_INSERT, TICKET_W'($urandom_range(16'hFFFF)), 7'd0, GRP_A);
        end
        repeat (NUM_QUEUES * QUEUE_DEPTH + 8)
            send_request(FUNC_SERVE, TICKET_W'($urandom_range(16'hFFFF)),
                         AGE_W'($urandom_range(127)), GROUP_W'($urandom_range(3)));
        wait_for_idle();
    endtask

    // mostly well-formed traffic; insert share shifts every 40 requests so the
    // queues both fill to the brim and run empty
    task automatic run_random_traffic(input int n_items);
        int                 insert_pct;
        int                 pick;
        logic [AGE_W-1:0]   ag;
        logic [GROUP_W-1:0] gp;
        insert_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                pick = $urandom_range(2);
                insert_pct = (pick == 0) ? 30 : (pick == 1) ? 55 : 75;
            end
            if ($urandom_range(99) < insert_pct)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    gp = GRP_A;
                else if (pick < 92)
                    gp = GRP_B;
                else
                    gp = $urandom_range(1) ? GRP_BAD_LO : GRP_BAD_HI;
                // a quarter of the ages sit on the threshold boundary
                if ($urandom_range(3) == 0)
                    ag = (age_thr_cfg == 0) ? 7'd0 :
                         AGE_W'(age_thr_cfg - AGE_W'($urandom_range(1)));
                else
                    ag = AGE_W'($urandom_range(127));
                send_request(FUNC_INSERT, TICKET_W'($urandom_range(16'hFFFF)), ag, gp);
            end
            else
                send_request(FUNC_SERVE, TICKET_W'($urandom_range(16'hFFFF)),
                             AGE_W'($urandom_range(127)), GROUP_W'($urandom_range(3)));
        end
    endtask

    // several register settings, extremes included, each under one of the idling modes
    task automatic test_turn_settings();
        logic [PDATA_W-1:0] junk;
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            wait_for_idle();
            // upper bits of the write data are noise in the later settings
            junk = (p >= 3) ? {$urandom} : '0;
            case (p)
                0:
                begin
                    write_register(REG_AGE_THR,      {junk[31:7], AGE_THR_RST});
                    write_register(REG_SENIOR_TURNS, {junk[31:4], SENIOR_TURNS_RST});
                    write_register(REG_ADULT_TURNS,  {junk[31:4], ADULT_TURNS_RST});
                    write_register(REG_B_TURNS,      {junk[31:4], B_TURNS_RST});
                end
                1:
                begin
                    // every group a entry is senior
                    write_register(REG_AGE_THR,      32'd0);
                    write_register(REG_SENIOR_TURNS, 32'd1);
                    write_register(REG_ADULT_TURNS,  32'd15);
                    write_register(REG_B_TURNS,      32'd15);
                end
                2:
                begin
                    // only the oldest age is senior
                    write_register(REG_AGE_THR,      32'd127);
                    write_register(REG_SENIOR_TURNS, 32'd15);
                    write_register(REG_ADULT_TURNS,  32'd1);
                    write_register(REG_B_TURNS,      32'd1);
                end
                3:
                begin
                    // zero turn counts act as single turns
                    write_register(REG_AGE_THR,      {junk[31:7], 7'($urandom_range(127))});
                    write_register(REG_SENIOR_TURNS, {junk[31:4], 4'd0});
                    write_register(REG_ADULT_TURNS,  {junk[31:4], 4'd0});
                    write_register(REG_B_TURNS,      {junk[31:4], 4'd0});
                end
                default:
                begin
                    write_register(REG_AGE_THR,      {junk[31:7], 7'($urandom_range(127))});
                    write_register(REG_SENIOR_TURNS, {junk[31:4], 4'($urandom_range(1, 15))});
                    write_register(REG_ADULT_TURNS,  {junk[31:4], 4'($urandom_range(1, 15))});
                    write_register(REG_B_TURNS,      {junk[31:4], 4'($urandom_range(1, 15))});
                end
            endcase
            // idling mode: none, sender gaps, receiver stalls, both
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 48;
                end
                default:
                begin
                    send_idle_pct = 15;
                    rsp_stall_pct = 15;
                end
            endcase
            run_random_traffic(PHASE_ITEMS);
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        // every block input known from time zero
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_INSERT;
        req_ch.ticket = '0;
        req_ch.age    = '0;
        req_ch.group  = GRP_A;
        rsp_ch.ready  = 1'b0;

        // predictor starts from the reset state of the block
        age_thr_cfg      = AGE_THR_RST;
        senior_turns_cfg = SENIOR_TURNS_RST;
        adult_turns_cfg  = ADULT_TURNS_RST;
        b_turns_cfg      = B_TURNS_RST;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            head_pos[q]   = 0;
            tail_pos[q]   = 0;
            fill_count[q] = 0;
        end
        start_phase(CL_SENIOR);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_backpressure_fill();
        test_turn_settings();

        // nothing owed any more; give stray results a chance to show up
        wait_for_idle();
        repeat (END_SETTLE) @(posedge clk);

        $display("covered %0d requests over %0d register writes: %0d stored, %0d served, %0d skipped",
                 requests_sent, reg_writes, seen_stored, seen_served, seen_skipped);
        $display("rejections seen: %0d queue full, %0d bad group, %0d all-empty serves",
                 seen_full, seen_bad_group, seen_all_empty);
        if (mismatch_count == 0)
            $display("three_class_weighted_fifo_scheduler test passed");
        else
            $display("three_class_weighted_fifo_scheduler test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout at %0t ns with %0d results pending", $time, pending_results.size());
        $display("three_class_weighted_fifo_scheduler test failed");
        $finish;
    end

endmodule

>>> three_class_weighted_fifo_scheduler.f
design/tcwfs_pkg.sv
design/tcwfs_if.sv
design/tcwfs_ram.sv
design/tcwfs_cfg.sv
design/tcwfs_ctrl.sv
design/tcwfs_dp.sv
design/three_class_weighted_fifo_scheduler.sv
test/tb.sv
